// ===== src/assert_macros.svh =====
// assertion macros shared by the gripper sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/gsc_pkg.sv =====
// types, codes and constants of the gripper sequencer
`default_nettype none
package gsc_pkg;

    // counter and register widths
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int FUNC_W     = 4;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    // command codes carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK        = 4'd0,
        FN_GATHER      = 4'd1,
        FN_EJECT       = 4'd2,
        FN_ADJUST      = 4'd3,
        FN_DROP        = 4'd4,
        FN_CLOSE       = 4'd5,
        FN_OPEN        = 4'd6,
        FN_STOP_SQZ    = 4'd7,
        FN_RESET       = 4'd8,
        FN_WHEELS_IN   = 4'd9,
        FN_WHEELS_OUT  = 4'd10,
        FN_STOP_WHEELS = 4'd11,
        FN_START_CFG   = 4'd12
    } t_func;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GATHER_SPIN = 3'd0,
        REG_EJECT_SPIN  = 3'd1,
        REG_ADJUST_OUT  = 3'd2,
        REG_DROP        = 3'd3,
        REG_GRAB_PAUSE  = 3'd4,
        REG_EJECT_STOP  = 3'd5,
        REG_SQUEEZE     = 3'd6,
        REG_RELEASE     = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
        16'd25, 16'd25, 16'd10, 16'd50, 16'd10, 16'd25, 16'd25, 16'd25
    };

    // wheel motor levels
    typedef enum logic [1:0] {
        WHEEL_OFF    = 2'd0,
        WHEEL_GATHER = 2'd1,
        WHEEL_EJECT  = 2'd2,
        WHEEL_ADJUST = 2'd3
    } t_wheel;

    // jaw motor levels
    typedef enum logic [1:0] {
        JAW_OFF     = 2'd0,
        JAW_SQUEEZE = 2'd1,
        JAW_RELEASE = 2'd2
    } t_jaw;

    // running sequence
    typedef enum logic [1:0] {
        SEQ_NONE   = 2'd0,
        SEQ_GATHER = 2'd1,
        SEQ_EJECT  = 2'd2,
        SEQ_ADJUST = 2'd3
    } t_seq;

    // sequence phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SPIN   = 3'b010,
        PH_FINISH = 3'b100
    } t_phase;

    // all timing registers as one bundle
    typedef struct packed {
        logic [CFG_W-1:0] gather_spin;
        logic [CFG_W-1:0] eject_spin;
        logic [CFG_W-1:0] adjust_out;
        logic [CFG_W-1:0] drop;
        logic [CFG_W-1:0] grab_pause;
        logic [CFG_W-1:0] eject_stop;
        logic [CFG_W-1:0] squeeze;
        logic [CFG_W-1:0] release_t;
    } t_cfg;

    // controller state
    typedef struct packed {
        logic                  cube_seen;
        logic                  holding;
        logic                  drop_active;
        logic [TIMER_BITS-1:0] drop_count;
        t_wheel                wheel_cmd;
        t_wheel                wheel_out;
        t_jaw                  jaw_cmd;
        logic                  jaw_moving;
        logic [TIMER_BITS-1:0] jaw_count;
        logic [CFG_W-1:0]      jaw_limit;
        logic                  claw_open;
        logic [TIMER_BITS-1:0] pause_count;
        logic [TIMER_BITS-1:0] release_count;
        t_seq                  active_seq;
        t_phase                seq_phase;
        logic [TIMER_BITS-1:0] seq_count;
    } t_state;

    localparam t_state STATE_RESET = '{
        cube_seen:     1'b0,
        holding:       1'b0,
        drop_active:   1'b0,
        drop_count:    '0,
        wheel_cmd:     WHEEL_OFF,
        wheel_out:     WHEEL_OFF,
        jaw_cmd:       JAW_OFF,
        jaw_moving:    1'b0,
        jaw_count:     '0,
        jaw_limit:     '0,
        claw_open:     1'b0,
        pause_count:   '0,
        release_count: '0,
        active_seq:    SEQ_NONE,
        seq_phase:     PH_IDLE,
        seq_count:     '0
    };

endpackage
`default_nettype wire

// ===== src/gsc_cfg_regs.sv =====
// timing register file written through the configuration port
`default_nettype none
module gsc_cfg_regs
    import gsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                      o_cfg
);

    logic [CFG_W-1:0] r_regs [NUM_REGS];

    // register write, defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= REG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_regs[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // each register has its own fixed tap
    assign o_cfg.gather_spin = r_regs[REG_GATHER_SPIN];
    assign o_cfg.eject_spin  = r_regs[REG_EJECT_SPIN];
    assign o_cfg.adjust_out  = r_regs[REG_ADJUST_OUT];
    assign o_cfg.drop        = r_regs[REG_DROP];
    assign o_cfg.grab_pause  = r_regs[REG_GRAB_PAUSE];
    assign o_cfg.eject_stop  = r_regs[REG_EJECT_STOP];
    assign o_cfg.squeeze     = r_regs[REG_SQUEEZE];
    assign o_cfg.release_t   = r_regs[REG_RELEASE];

endmodule
`default_nettype wire

// ===== src/gsc_step.sv =====
// next-state logic for one command or tick beat
`default_nettype none
module gsc_step
    import gsc_pkg::*;
(
    input  wire t_state            i_state,
    input  wire t_cfg              i_cfg,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic              i_cube_sensor,
    output t_state                 o_state
);

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // counter reached limit, both zero extended
    function automatic logic cnt_ge(input logic [TIMER_BITS-1:0] cnt,
                                    input logic [CFG_W-1:0] lim);
        return CMP_W'(cnt) >= CMP_W'(lim);
    endfunction

    function automatic t_state wheels_stop(input t_state st);
        t_state s;
        s = st;
        s.wheel_cmd = WHEEL_OFF;
        s.holding   = 1'b0;
        return s;
    endfunction

    function automatic t_state wheels_start(input t_state st, input logic inward);
        t_state s;
        s = st;
        if (inward) begin
            s.wheel_cmd = WHEEL_GATHER;
            if (!s.holding) begin
                s.holding     = 1'b1;
                s.pause_count = '0;
            end
        end else begin
            s.wheel_cmd = (s.active_seq == SEQ_ADJUST) ? WHEEL_ADJUST : WHEEL_EJECT;
            if (s.holding) begin
                s.holding       = 1'b0;
                s.release_count = '0;
            end
        end
        return s;
    endfunction

    function automatic t_state jaw_move(input t_state st, input t_jaw code,
                                        input logic open, input logic [CFG_W-1:0] lim);
        t_state s;
        s = st;
        if (s.jaw_cmd != code) begin
            s.jaw_count = '0;
        end
        s.jaw_cmd    = code;
        s.jaw_moving = 1'b1;
        s.claw_open  = open;
        s.jaw_limit  = lim;
        return s;
    endfunction

    function automatic t_state start_seq(input t_state st, input t_seq which);
        t_state s;
        s = st;
        if (s.active_seq != which) begin
            s.active_seq = which;
            s.seq_phase  = PH_IDLE;
        end
        return s;
    endfunction

    logic [CFG_W-1:0] spin_limit;

    // spin time of the running sequence
    always_comb begin
        case (i_state.active_seq)
            SEQ_GATHER: spin_limit = i_cfg.gather_spin;
            SEQ_EJECT:  spin_limit = i_cfg.eject_spin;
            default:    spin_limit = i_cfg.adjust_out;
        endcase
    end

    // one event applied to the state
    always_comb begin
        t_state s;
        s = i_state;
        case (i_func)
            FN_TICK: begin
                // sensor sample and drop timer
                s.cube_seen = !s.claw_open && !i_cube_sensor;
                if (s.drop_active) begin
                    s.drop_count = sat_inc(s.drop_count);
                    if (cnt_ge(s.drop_count, i_cfg.drop)) begin
                        s.drop_active = 1'b0;
                    end
                end
                // sequence step
                if (s.active_seq != SEQ_NONE) begin
                    case (s.seq_phase)
                        PH_IDLE: begin
                            s = wheels_stop(s);
                            s.seq_count = '0;
                            if (s.active_seq != SEQ_GATHER) begin
                                s.release_count = '0;
                            end
                            s.seq_phase = PH_SPIN;
                        end
                        PH_SPIN: begin
                            s = wheels_start(s, s.active_seq == SEQ_GATHER);
                            if (!cnt_ge(s.seq_count, spin_limit)) begin
                                s.seq_count = sat_inc(s.seq_count);
                            end else begin
                                s.seq_count = '0;
                                s.seq_phase = PH_FINISH;
                            end
                        end
                        PH_FINISH: begin
                            if (s.active_seq == SEQ_GATHER) begin
                                s = jaw_move(s, JAW_SQUEEZE, 1'b0, i_cfg.squeeze);
                                s.active_seq = SEQ_NONE;
                            end else if (s.active_seq == SEQ_EJECT) begin
                                s = jaw_move(s, JAW_RELEASE, 1'b1, i_cfg.release_t);
                                s.active_seq = SEQ_NONE;
                            end else begin
                                s.active_seq = SEQ_GATHER;
                            end
                            s.seq_phase = PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                // wheel pause while holding, stop after eject
                if (s.holding) begin
                    if (!s.cube_seen) begin
                        s.wheel_out   = s.wheel_cmd;
                        s.pause_count = '0;
                    end else begin
                        if (cnt_ge(s.pause_count, i_cfg.grab_pause)) begin
                            s.wheel_out = WHEEL_OFF;
                        end
                        s.pause_count = sat_inc(s.pause_count);
                    end
                end else begin
                    s.wheel_out = s.wheel_cmd;
                    if (cnt_ge(s.release_count, i_cfg.eject_stop)) begin
                        s = wheels_stop(s);
                    end
                    s.release_count = sat_inc(s.release_count);
                end
                // jaw move timeout
                if (s.jaw_moving) begin
                    s.jaw_count = sat_inc(s.jaw_count);
                    if (cnt_ge(s.jaw_count, s.jaw_limit)) begin
                        s.jaw_limit  = '0;
                        s.jaw_cmd    = JAW_OFF;
                        s.jaw_moving = 1'b0;
                    end
                end
            end
            FN_GATHER: s = start_seq(s, SEQ_GATHER);
            FN_EJECT:  s = start_seq(s, SEQ_EJECT);
            FN_ADJUST: s = start_seq(s, SEQ_ADJUST);
            FN_DROP: begin
                if (!s.drop_active) begin
                    s.drop_count = '0;
                end
                s.drop_active = 1'b1;
            end
            FN_CLOSE:       s = jaw_move(s, JAW_SQUEEZE, 1'b0, i_cfg.squeeze);
            FN_OPEN:        s = jaw_move(s, JAW_RELEASE, 1'b1, i_cfg.release_t);
            FN_STOP_SQZ:    s.jaw_cmd = JAW_OFF;
            FN_RESET:       s = STATE_RESET;
            FN_WHEELS_IN:   s = wheels_start(s, 1'b1);
            FN_WHEELS_OUT:  s = wheels_start(s, 1'b0);
            FN_STOP_WHEELS: s = wheels_stop(s);
            FN_START_CFG: begin
                s = wheels_stop(s);
                s = jaw_move(s, JAW_SQUEEZE, 1'b0, i_cfg.squeeze);
            end
            default: begin
            end
        endcase
        o_state = s;
    end

endmodule
`default_nettype wire

// ===== src/gripper_sequence_controller_core.sv =====
// top level of the gripper sequencer: state, result register and handshakes
//
// Usage:
//   Input stream: each beat is one event. s_axis_tuser carries the command
//   code (0 tick, 1..12 commands), s_axis_tdata bit 0 the raw cube sensor
//   level, sampled on ticks only. Unused codes leave the state alone.
//   Output stream: one beat per accepted event with the motor and status
//   levels after that event.
//   Timing registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while no event is in flight.
//   Latency: the result is valid on the cycle after the input beat is taken.
//   Throughput: one event per cycle unless the output stalls; the state update is
//   a single pass of compare and counter logic feeding the state and result registers.
//   The input is ready whenever the result register is empty or its beat is
//   taken in the same cycle, so a stall on the output holds one result and
//   then stalls the input.
//   Reset (synchronous, active low) clears all state, restores the register
//   defaults and empties the result register.
`default_nettype none
`include "assert_macros.svh"
module gripper_sequence_controller_core
    import gsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input event stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,  // [0] cube_sensor, [7:1] zero
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // [3:0] func
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [1:0] wheel_drive, [3:2] squeeze_drive,
                                                     // [4] drop_relay, [5] cube_present,
                                                     // [6] jaw_open, [7] zero
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg       cfg;
    t_state     r_st;
    t_state     n_st;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       in_beat;

    // timing registers
    gsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // event logic
    gsc_step u_step (
        .i_state       (r_st),
        .i_cfg         (cfg),
        .i_func        (s_axis_tuser),
        .i_cube_sensor (s_axis_tdata[0]),
        .o_state       (n_st)
    );

    // handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (in_beat) begin
            r_st <= n_st;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= {1'b0, n_st.claw_open, n_st.cube_seen, n_st.drop_active,
                           n_st.jaw_cmd, n_st.wheel_out};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `ASSERT_CLKD(a_beat_gives_result, in_beat |=> r_out_valid, "accepted beat left no result")
    `ASSERT_CLKD(a_jaw_idle_off, !r_st.jaw_moving |-> r_st.jaw_cmd == JAW_OFF, "jaw driven while not moving")
    `ASSERT_CLKD(a_no_seq_idle, r_st.active_seq == SEQ_NONE |-> r_st.seq_phase == PH_IDLE, "phase set with no sequence")
    `ASSERT_CLKD(a_drop_starts, in_beat && s_axis_tuser == FN_DROP |=> r_st.drop_active, "drop command did not start relay")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
`default_nettype wire
